FILE: rtl/core/mbw_pkg.sv
// mbw_pkg: shared types and constants of the maze backtracker walk
// state encoding, result codes, directions and controller/datapath structs
// no dependencies
`timescale 1ns / 1ps

package mbw_pkg;

    localparam int CFG_DATA_W = 6;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'd1;

    localparam logic [CFG_DATA_W-1:0] GRID_SIDE_RESET = 6'd8;

    localparam logic [1:0] DIR_N = 2'd0;
    localparam logic [1:0] DIR_S = 2'd1;
    localparam logic [1:0] DIR_E = 2'd2;
    localparam logic [1:0] DIR_W = 2'd3;

    localparam logic KIND_START = 1'b0;

    typedef enum logic [1:0] {
        ST_STARTED  = 2'd0,
        ST_CARVED   = 2'd1,
        ST_COMPLETE = 2'd2,
        ST_NO_START = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ROW_N = 2'd0,
        ROW_C = 2'd1,
        ROW_S = 2'd2
    } t_row_sel;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHK,
        S_CLEAR,
        S_RN,
        S_RC,
        S_RS,
        S_SCAP,
        S_PICK,
        S_POPW
    } t_state;

    typedef struct packed {
        logic     take_item;
        logic     start_init;
        logic     clr_row;
        logic     rd_en;
        t_row_sel rd_sel;
        logic     cap_en;
        t_row_sel cap_sel;
        logic     pop;
        logic     top_load;
        logic     carve;
        logic     out_load;
        t_status  out_code;
    } t_cmd;

    typedef struct packed {
        logic kind;
        logic started;
        logic complete;
        logic clr_last;
        logic open_any;
        logic fill_one;
        logic out_free;
    } t_stat;

    // value mod 3: base-4 digits all weigh 1 mod 3
    function automatic logic [1:0] mod3(input logic [15:0] v);
        logic [4:0] s;
        logic [2:0] t;
        s = '0;
        for (int i = 0; i < 8; i++) begin
            s = s + 5'(v[2*i +: 2]);
        end
        t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
        if (t >= 3'd6) begin
            t = t - 3'd6;
        end else if (t >= 3'd3) begin
            t = t - 3'd3;
        end
        return t[1:0];
    endfunction

endpackage

FILE: rtl/core/mbw_ifs.sv
// mbw_ifs: valid/ready channels of the maze backtracker walk
// item input, result output and register write port
// depends on mbw_pkg
`timescale 1ns / 1ps

interface mbw_item_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [15:0] random_word;

    modport source (output valid, output kind, output random_word, input ready);
    modport sink   (input valid, input kind, input random_word, output ready);
endinterface

interface mbw_result_if #(parameter int COORD_W = 5);
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [COORD_W-1:0] from_x;
    logic [COORD_W-1:0] from_y;
    logic [1:0]         direction;
    logic               last_carve;

    modport source (output valid, output status, output from_x, output from_y,
                    output direction, output last_carve, input ready);
    modport sink   (input valid, input status, input from_x, input from_y,
                    input direction, input last_carve, output ready);
endinterface

interface mbw_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [mbw_pkg::CFG_IDX_W-1:0]  index;
    logic [mbw_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/maze_backtracker_walk.sv
// maze_backtracker_walk: depth-first maze carving, top level
// start word: check, then one visited row cleared per cycle, marks swept on each start;
//   the result loads with the last row once the result register is free
// step word: check, three row reads on the single-port row ram, pick; each backtrack pop
//   adds a stack read and the row reads again; one word at a time: next word taken the
//   cycle after result loads; reset clears control state, started flag, sizes to 8 by 8
`timescale 1ns / 1ps

module maze_backtracker_walk #(
    parameter int MAX_SIDE = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mbw_item_if.sink     i_item,
    mbw_result_if.source o_result,
    mbw_cfg_if.sink      i_cfg
);

    mbw_pkg::t_cmd  cmd;
    mbw_pkg::t_stat stat;

    mbw_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (i_item.valid),
        .o_item_ready (i_item.ready),
        .i_stat       (stat),
        .o_cmd        (cmd)
    );

    mbw_dpath #(.MAX_SIDE(MAX_SIDE)) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .i_item   (i_item),
        .o_result (o_result),
        .i_cfg    (i_cfg)
    );

endmodule

FILE: rtl/core/mbw_ram.sv
// mbw_ram: generic single-port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module mbw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/mbw_ctrl.sv
// mbw_ctrl: sequencer of the maze backtracker walk
// issues datapath commands per item: clear sweep, neighbor reads, pop, carve
// depends on mbw_pkg
`timescale 1ns / 1ps

module mbw_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_item_valid,
    output logic           o_item_ready,
    input  mbw_pkg::t_stat i_stat,
    output mbw_pkg::t_cmd  o_cmd
);

    mbw_pkg::t_state r_state;
    mbw_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mbw_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mbw_pkg::S_IDLE: begin
                if (i_item_valid) begin
                    n_state = mbw_pkg::S_CHK;
                end
            end
            mbw_pkg::S_CHK: begin
                if (i_stat.kind == mbw_pkg::KIND_START) begin
                    n_state = mbw_pkg::S_CLEAR;
                end else if (!i_stat.started || i_stat.complete) begin
                    if (i_stat.out_free) begin
                        n_state = mbw_pkg::S_IDLE;
                    end
                end else begin
                    n_state = mbw_pkg::S_RN;
                end
            end
            mbw_pkg::S_CLEAR: begin
                if (i_stat.clr_last && i_stat.out_free) begin
                    n_state = mbw_pkg::S_IDLE;
                end
            end
            mbw_pkg::S_RN:   n_state = mbw_pkg::S_RC;
            mbw_pkg::S_RC:   n_state = mbw_pkg::S_RS;
            mbw_pkg::S_RS:   n_state = mbw_pkg::S_SCAP;
            mbw_pkg::S_SCAP: n_state = mbw_pkg::S_PICK;
            mbw_pkg::S_PICK: begin
                if (i_stat.open_any || i_stat.fill_one) begin
                    if (i_stat.out_free) begin
                        n_state = mbw_pkg::S_IDLE;
                    end
                end else begin
                    n_state = mbw_pkg::S_POPW;
                end
            end
            mbw_pkg::S_POPW: n_state = mbw_pkg::S_RN;
            default:         n_state = mbw_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_item_ready = 1'b0;
        o_cmd        = '0;
        o_cmd.rd_sel   = mbw_pkg::ROW_C;
        o_cmd.cap_sel  = mbw_pkg::ROW_C;
        o_cmd.out_code = mbw_pkg::ST_STARTED;
        unique case (r_state)
            mbw_pkg::S_IDLE: begin
                o_item_ready    = 1'b1;
                o_cmd.take_item = i_item_valid;
            end
            mbw_pkg::S_CHK: begin
                if (i_stat.kind == mbw_pkg::KIND_START) begin
                    o_cmd.start_init = 1'b1;
                end else if (!i_stat.started) begin
                    o_cmd.out_load = i_stat.out_free;
                    o_cmd.out_code = mbw_pkg::ST_NO_START;
                end else if (i_stat.complete) begin
                    o_cmd.out_load = i_stat.out_free;
                    o_cmd.out_code = mbw_pkg::ST_COMPLETE;
                end
            end
            mbw_pkg::S_CLEAR: begin
                o_cmd.clr_row  = 1'b1;
                o_cmd.out_load = i_stat.clr_last && i_stat.out_free;
                o_cmd.out_code = mbw_pkg::ST_STARTED;
            end
            mbw_pkg::S_RN: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = mbw_pkg::ROW_N;
            end
            mbw_pkg::S_RC: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_sel  = mbw_pkg::ROW_C;
                o_cmd.cap_en  = 1'b1;
                o_cmd.cap_sel = mbw_pkg::ROW_N;
            end
            mbw_pkg::S_RS: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_sel  = mbw_pkg::ROW_S;
                o_cmd.cap_en  = 1'b1;
                o_cmd.cap_sel = mbw_pkg::ROW_C;
            end
            mbw_pkg::S_SCAP: begin
                o_cmd.cap_en  = 1'b1;
                o_cmd.cap_sel = mbw_pkg::ROW_S;
            end
            mbw_pkg::S_PICK: begin
                if (i_stat.open_any) begin
                    o_cmd.carve = i_stat.out_free;
                end else if (i_stat.fill_one) begin
                    // last cell popped: walk is over
                    o_cmd.pop      = i_stat.out_free;
                    o_cmd.out_load = i_stat.out_free;
                    o_cmd.out_code = mbw_pkg::ST_COMPLETE;
                end else begin
                    o_cmd.pop = 1'b1;
                end
            end
            mbw_pkg::S_POPW: begin
                o_cmd.top_load = 1'b1;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    a_pop_reread: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mbw_pkg::S_POPW) |=> (r_state == mbw_pkg::S_RN))
        else $error("pop not followed by neighbor reread");

    a_ready_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.take_item) |=> (r_state == mbw_pkg::S_CHK))
        else $error("accepted word not checked");

    a_carve_after_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.carve |-> ($past(r_state) == mbw_pkg::S_SCAP || $past(r_state) == mbw_pkg::S_PICK))
        else $error("carve without fresh neighbor rows");

endmodule

FILE: rtl/core/mbw_dpath.sv
// mbw_dpath: datapath of the maze backtracker walk
// visited-row ram, walk stack ram, counters, neighbor pick and result register
// depends on mbw_pkg, mbw_ifs, mbw_ram
`timescale 1ns / 1ps

module mbw_dpath #(
    parameter int MAX_SIDE = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  mbw_pkg::t_cmd i_cmd,
    output mbw_pkg::t_stat o_stat,
    mbw_item_if.sink      i_item,
    mbw_result_if.source  o_result,
    mbw_cfg_if.sink       i_cfg
);

    localparam int CW    = $clog2(MAX_SIDE);
    localparam int SW    = $clog2(MAX_SIDE + 1);
    localparam int CELLS = MAX_SIDE * MAX_SIDE;
    localparam int AW    = $clog2(CELLS);
    localparam int FW    = AW + 1;

    // configuration
    logic [mbw_pkg::CFG_DATA_W-1:0] r_cfg_w;
    logic [mbw_pkg::CFG_DATA_W-1:0] r_cfg_h;

    // walk state
    logic [SW-1:0] r_live_w;
    logic [SW-1:0] r_live_h;
    logic [FW-1:0] r_total;
    logic [FW-1:0] r_fill;
    logic [FW-1:0] r_visited;
    logic          r_started;
    logic [CW-1:0] r_top_x;
    logic [CW-1:0] r_top_y;
    logic [CW-1:0] r_clr_row;

    // item
    logic       r_kind;
    logic [1:0] r_rnd2;
    logic [1:0] r_mod3;

    // captured visited rows
    logic [MAX_SIDE-1:0] r_row_n;
    logic [MAX_SIDE-1:0] r_row_c;
    logic [MAX_SIDE-1:0] r_row_s;

    // result register
    logic                r_out_valid;
    mbw_pkg::t_status    r_status;
    logic [CW-1:0]       r_from_x;
    logic [CW-1:0]       r_from_y;
    logic [1:0]          r_dir;
    logic                r_last;

    logic [SW-1:0]       clamp_w;
    logic [SW-1:0]       clamp_h;
    logic [2*SW-1:0]     area;
    logic                has_n;
    logic                has_s;
    logic                has_e;
    logic                has_w;
    logic [CW-1:0]       e_idx;
    logic [CW-1:0]       w_idx;
    logic [3:0]          open;
    logic [2:0]          open_cnt;
    logic [1:0]          pick_idx;
    logic [1:0]          dir;
    logic [1:0]          rank;
    logic                found;
    logic [CW-1:0]       nx;
    logic [CW-1:0]       ny;
    logic [MAX_SIDE-1:0] base_row;
    logic [MAX_SIDE-1:0] new_row;
    logic [FW-1:0]       fill_m2;
    logic                out_free;

    logic                row_we;
    logic [CW-1:0]       row_addr;
    logic [MAX_SIDE-1:0] row_wdata;
    logic [MAX_SIDE-1:0] row_rdata;
    logic                stk_we;
    logic [AW-1:0]       stk_addr;
    logic [2*CW-1:0]     stk_wdata;
    logic [2*CW-1:0]     stk_rdata;

    function automatic logic [SW-1:0] clamp_side(input logic [mbw_pkg::CFG_DATA_W-1:0] v);
        logic [SW-1:0] r;
        if (v == '0) begin
            r = SW'(1);
        end else if (int'(v) > MAX_SIDE) begin
            r = SW'(MAX_SIDE);
        end else begin
            r = SW'(v);
        end
        return r;
    endfunction

    assign clamp_w = clamp_side(r_cfg_w);
    assign clamp_h = clamp_side(r_cfg_h);
    assign area    = (2*SW)'(clamp_w) * (2*SW)'(clamp_h);

    // neighbor availability from the captured rows
    assign has_n = (r_top_y != '0);
    assign has_s = ((SW'(r_top_y) + SW'(1)) < r_live_h);
    assign has_e = ((SW'(r_top_x) + SW'(1)) < r_live_w);
    assign has_w = (r_top_x != '0);
    assign e_idx = has_e ? (r_top_x + CW'(1)) : r_top_x;
    assign w_idx = has_w ? (r_top_x - CW'(1)) : r_top_x;

    assign open[0] = has_n && !r_row_n[r_top_x];
    assign open[1] = has_s && !r_row_s[r_top_x];
    assign open[2] = has_e && !r_row_c[e_idx];
    assign open[3] = has_w && !r_row_c[w_idx];
    assign open_cnt = 3'($countones(open));

    always_comb begin
        case (open_cnt)
            3'd2:    pick_idx = {1'b0, r_rnd2[0]};
            3'd3:    pick_idx = r_mod3;
            3'd4:    pick_idx = r_rnd2;
            default: pick_idx = 2'd0;
        endcase
    end

    // pick_idx-th open direction in the order n, s, e, w
    always_comb begin
        dir   = mbw_pkg::DIR_N;
        rank  = 2'd0;
        found = 1'b0;
        for (int k = 0; k < 4; k++) begin
            if (open[k] && !found) begin
                if (rank == pick_idx) begin
                    dir   = 2'(k);
                    found = 1'b1;
                end
                rank = rank + 2'd1;
            end
        end
    end

    always_comb begin
        nx       = r_top_x;
        ny       = r_top_y;
        base_row = r_row_c;
        case (dir)
            mbw_pkg::DIR_N: begin
                ny       = r_top_y - CW'(1);
                base_row = r_row_n;
            end
            mbw_pkg::DIR_S: begin
                ny       = r_top_y + CW'(1);
                base_row = r_row_s;
            end
            mbw_pkg::DIR_E: nx = e_idx;
            default:        nx = w_idx;
        endcase
    end

    assign new_row  = base_row | (MAX_SIDE'(1) << nx);
    assign fill_m2  = r_fill - FW'(2);
    assign out_free = !r_out_valid || o_result.ready;

    // visited-row ram port
    always_comb begin
        row_we    = i_cmd.clr_row || i_cmd.carve;
        row_wdata = new_row;
        row_addr  = r_top_y;
        if (i_cmd.clr_row) begin
            row_addr  = r_clr_row;
            row_wdata = (r_clr_row == '0) ? MAX_SIDE'(1) : '0;
        end else if (i_cmd.carve) begin
            row_addr = ny;
        end else if (i_cmd.rd_en) begin
            case (i_cmd.rd_sel)
                mbw_pkg::ROW_N: row_addr = r_top_y - CW'(1);
                mbw_pkg::ROW_S: row_addr = r_top_y + CW'(1);
                default:        row_addr = r_top_y;
            endcase
        end
    end

    // walk stack ram port
    always_comb begin
        stk_we    = i_cmd.start_init || i_cmd.carve;
        stk_wdata = {ny, nx};
        stk_addr  = fill_m2[AW-1:0];
        if (i_cmd.start_init) begin
            stk_addr  = '0;
            stk_wdata = '0;
        end else if (i_cmd.carve) begin
            stk_addr = r_fill[AW-1:0];
        end
    end

    mbw_ram #(.WIDTH(MAX_SIDE), .DEPTH(MAX_SIDE)) u_rows (
        .i_clk   (i_clk),
        .i_we    (row_we),
        .i_addr  (row_addr),
        .i_wdata (row_wdata),
        .o_rdata (row_rdata)
    );

    mbw_ram #(.WIDTH(2*CW), .DEPTH(CELLS)) u_stack (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_addr  (stk_addr),
        .i_wdata (stk_wdata),
        .o_rdata (stk_rdata)
    );

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w     <= mbw_pkg::GRID_SIDE_RESET;
            r_cfg_h     <= mbw_pkg::GRID_SIDE_RESET;
            r_live_w    <= SW'(8);
            r_live_h    <= SW'(8);
            r_total     <= '0;
            r_fill      <= '0;
            r_visited   <= '0;
            r_started   <= 1'b0;
            r_top_x     <= '0;
            r_top_y     <= '0;
            r_clr_row   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    mbw_pkg::CFG_GRID_WIDTH:  r_cfg_w <= i_cfg.data;
                    mbw_pkg::CFG_GRID_HEIGHT: r_cfg_h <= i_cfg.data;
                    default: ;
                endcase
            end
            if (i_cmd.start_init) begin
                r_live_w  <= clamp_w;
                r_live_h  <= clamp_h;
                r_total   <= FW'(area);
                r_fill    <= FW'(1);
                r_visited <= FW'(1);
                r_started <= 1'b1;
                r_top_x   <= '0;
                r_top_y   <= '0;
                r_clr_row <= '0;
            end
            if (i_cmd.clr_row && (r_clr_row != CW'(MAX_SIDE - 1))) begin
                r_clr_row <= r_clr_row + CW'(1);
            end
            if (i_cmd.pop) begin
                r_fill <= r_fill - FW'(1);
            end
            if (i_cmd.top_load) begin
                {r_top_y, r_top_x} <= stk_rdata;
            end
            if (i_cmd.carve) begin
                r_fill    <= r_fill + FW'(1);
                r_visited <= r_visited + FW'(1);
                r_top_x   <= nx;
                r_top_y   <= ny;
            end
            if (i_cmd.out_load || i_cmd.carve) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_item) begin
            r_kind <= i_item.kind;
            r_rnd2 <= i_item.random_word[1:0];
            r_mod3 <= mbw_pkg::mod3(i_item.random_word);
        end
        if (i_cmd.cap_en) begin
            case (i_cmd.cap_sel)
                mbw_pkg::ROW_N: r_row_n <= row_rdata;
                mbw_pkg::ROW_S: r_row_s <= row_rdata;
                default:        r_row_c <= row_rdata;
            endcase
        end
        if (i_cmd.carve) begin
            r_status <= mbw_pkg::ST_CARVED;
            r_from_x <= r_top_x;
            r_from_y <= r_top_y;
            r_dir    <= dir;
            r_last   <= ((r_visited + FW'(1)) >= r_total);
        end else if (i_cmd.out_load) begin
            r_status <= i_cmd.out_code;
            r_from_x <= '0;
            r_from_y <= '0;
            r_dir    <= mbw_pkg::DIR_N;
            r_last   <= 1'b0;
        end
    end

    assign o_stat.kind     = r_kind;
    assign o_stat.started  = r_started;
    assign o_stat.complete = (r_visited >= r_total) || (r_fill == '0);
    assign o_stat.clr_last = (r_clr_row == CW'(MAX_SIDE - 1));
    assign o_stat.open_any = (open != '0);
    assign o_stat.fill_one = (r_fill == FW'(1));
    assign o_stat.out_free = out_free;

    assign o_result.valid      = r_out_valid;
    assign o_result.status     = r_status;
    assign o_result.from_x     = r_from_x;
    assign o_result.from_y     = r_from_y;
    assign o_result.direction  = r_dir;
    assign o_result.last_carve = r_last;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.out_load || i_cmd.carve) |-> out_free)
        else $error("result word overwritten before taken");

    a_carve_has_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.carve |-> (open != '0) && (r_visited < r_total))
        else $error("carve with no open neighbor or grid full");

    a_visited_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_started |-> (r_visited <= r_total) && (r_fill <= r_visited))
        else $error("visited count or stack fill out of range");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |-> (r_fill != '0))
        else $error("pop from empty walk stack");

endmodule

FILE: bench/mbw_walk_checker.sv
// mbw_walk_checker: watches the item, result and register channels of the maze walker,
// predicts each result word from its own copy of the grid and compares them in order
// depends on mbw_pkg and mbw_ifs
`timescale 1ns / 1ps

module mbw_walk_checker #(
    parameter int MAX_SIDE = 32
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    mbw_item_if   item_ch,
    mbw_result_if result_ch,
    mbw_cfg_if    cfg_ch,
    output int    o_fail_count,
    output int    o_pending
);

    localparam int CELL_COUNT = MAX_SIDE * MAX_SIDE;

    localparam logic [4:0] MARK_SEEN = 5'b00001;
    localparam logic [4:0] MARK_N    = 5'b00010;
    localparam logic [4:0] MARK_S    = 5'b00100;
    localparam logic [4:0] MARK_E    = 5'b01000;
    localparam logic [4:0] MARK_W    = 5'b10000;

    typedef struct packed {
        mbw_pkg::t_status status;
        logic [4:0]       from_x;
        logic [4:0]       from_y;
        logic [1:0]       direction;
        logic             last_carve;
    } t_walk_word;

    logic [4:0]  cell_mark [CELL_COUNT];
    int unsigned trail [CELL_COUNT];
    int unsigned trail_fill;
    int unsigned visited;
    int unsigned live_w;
    int unsigned live_h;
    logic [5:0]  width_reg;
    logic [5:0]  height_reg;
    bit          started_flag;
    t_walk_word  expected_words [$];
    int          errs = 0;

    function automatic int unsigned used_side(logic [5:0] v);
        if (v == 0) return 1;
        if (v > MAX_SIDE) return MAX_SIDE;
        return v;
    endfunction

    function automatic bit is_fresh(int unsigned x, int unsigned y);
        return cell_mark[(y * MAX_SIDE + x) % CELL_COUNT][0] == 1'b0;
    endfunction

    // unvisited neighbors in north, south, east, west order
    function automatic int unsigned open_dirs(int unsigned x, int unsigned y,
                                              output logic [3:0][1:0] dirs);
        int unsigned n;
        n = 0;
        dirs = '0;
        if (y > 0 && is_fresh(x, y - 1)) begin
            dirs[n] = mbw_pkg::DIR_N;
            n++;
        end
        if (y + 1 < live_h && is_fresh(x, y + 1)) begin
            dirs[n] = mbw_pkg::DIR_S;
            n++;
        end
        if (x + 1 < live_w && is_fresh(x + 1, y)) begin
            dirs[n] = mbw_pkg::DIR_E;
            n++;
        end
        if (x > 0 && is_fresh(x - 1, y)) begin
            dirs[n] = mbw_pkg::DIR_W;
            n++;
        end
        return n;
    endfunction

    function automatic t_walk_word walk_advance(logic kind, logic [15:0] rnd);
        t_walk_word      w;
        logic [3:0][1:0] dirs;
        logic [1:0]      dir;
        int unsigned     x, y, n, here, there;
        w = '0;
        w.status = mbw_pkg::ST_STARTED;
        x = 0;
        y = 0;
        n = 0;
        if (kind == mbw_pkg::KIND_START) begin
            live_w = used_side(width_reg);
            live_h = used_side(height_reg);
            foreach (cell_mark[i]) cell_mark[i] = '0;
            trail[0] = 0;
            trail_fill = 1;
            cell_mark[0] = MARK_SEEN;
            visited = 1;
            started_flag = 1'b1;
            return w;
        end
        if (!started_flag) begin
            w.status = mbw_pkg::ST_NO_START;
            return w;
        end
        if (visited >= live_w * live_h) begin
            w.status = mbw_pkg::ST_COMPLETE;
            return w;
        end
        // back up while the top cell is boxed in
        while (trail_fill > 0) begin
            here = trail[trail_fill - 1] % CELL_COUNT;
            x = here % MAX_SIDE;
            y = here / MAX_SIDE;
            n = open_dirs(x, y, dirs);
            if (n > 0) break;
            trail_fill--;
        end
        if (n == 0) begin
            w.status = mbw_pkg::ST_COMPLETE;
            return w;
        end
        dir = dirs[rnd % n];
        here = y * MAX_SIDE + x;
        case (dir)
            mbw_pkg::DIR_N: begin
                there = here - MAX_SIDE;
                cell_mark[here] |= MARK_N;
                cell_mark[there] |= MARK_S;
            end
            mbw_pkg::DIR_S: begin
                there = here + MAX_SIDE;
                cell_mark[here] |= MARK_S;
                cell_mark[there] |= MARK_N;
            end
            mbw_pkg::DIR_E: begin
                there = here + 1;
                cell_mark[here] |= MARK_E;
                cell_mark[there] |= MARK_W;
            end
            default: begin
                there = here - 1;
                cell_mark[here] |= MARK_W;
                cell_mark[there] |= MARK_E;
            end
        endcase
        cell_mark[there] |= MARK_SEEN;
        if (trail_fill < CELL_COUNT) begin
            trail[trail_fill] = there;
            trail_fill++;
        end
        visited++;
        w.status = mbw_pkg::ST_CARVED;
        w.from_x = 5'(x);
        w.from_y = 5'(y);
        w.direction = dir;
        w.last_carve = visited >= live_w * live_h;
        return w;
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            errs++;
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_walk_word want;
        if (!i_rst_n) begin
            width_reg = mbw_pkg::GRID_SIDE_RESET;
            height_reg = mbw_pkg::GRID_SIDE_RESET;
            live_w = used_side(mbw_pkg::GRID_SIDE_RESET);
            live_h = used_side(mbw_pkg::GRID_SIDE_RESET);
            foreach (cell_mark[i]) cell_mark[i] = '0;
            trail_fill = 0;
            visited = 0;
            started_flag = 1'b0;
            expected_words.delete();
        end else begin
            // results first, so a word accepted at this edge cannot pair with one
            if (result_ch.valid && result_ch.ready) begin
                if (expected_words.size() == 0) begin
                    errs++;
                    $display("%0t: unexpected result word: expected none, got status %0d",
                             $time, result_ch.status);
                end else begin
                    want = expected_words.pop_front();
                    check_field("status", want.status, result_ch.status);
                    check_field("from_x", want.from_x, result_ch.from_x);
                    check_field("from_y", want.from_y, result_ch.from_y);
                    check_field("direction", want.direction, result_ch.direction);
                    check_field("last_carve", want.last_carve, result_ch.last_carve);
                end
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                if (cfg_ch.index == mbw_pkg::CFG_GRID_WIDTH) begin
                    width_reg = cfg_ch.data;
                end else if (cfg_ch.index == mbw_pkg::CFG_GRID_HEIGHT) begin
                    height_reg = cfg_ch.data;
                end
            end
            if (item_ch.valid && item_ch.ready) begin
                expected_words.insert(expected_words.size(),
                                      walk_advance(item_ch.kind, item_ch.random_word));
            end
        end
        o_fail_count <= errs;
        o_pending <= expected_words.size();
    end

endmodule

FILE: bench/tb_maze_backtracker_walk.sv
// tb_maze_backtracker_walk: drives start and step words and register writes into the
// maze walker with random gaps and stalls; verdict from the checker's failure and pending counts
// depends on mbw_pkg, mbw_ifs, maze_backtracker_walk and mbw_walk_checker
`timescale 1ns / 1ps

module tb_maze_backtracker_walk;

    localparam int   MAX_SIDE       = 32;
    localparam int   ITEM_TARGET    = 1600;
    localparam int   LONG_HOLD      = 300;
    localparam int   SETTLE_CYCLES  = 40;
    localparam int   WATCHDOG_LIMIT = 20000;
    localparam logic KIND_STEP      = ~mbw_pkg::KIND_START;

    logic i_clk = 1'b0;
    logic i_rst_n;
    bit   idle_on = 1'b1;
    bit   hold_req = 1'b0;
    int   words_sent = 0;
    int   idle_cycles = 0;
    int   fail_count;
    int   pending;

    mbw_item_if                  item_if ();
    mbw_result_if #(.COORD_W(5)) res_if ();
    mbw_cfg_if                   cfg_if ();

    maze_backtracker_walk #(
        .MAX_SIDE(MAX_SIDE)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_if),
        .o_result(res_if),
        .i_cfg   (cfg_if)
    );

    mbw_walk_checker #(
        .MAX_SIDE(MAX_SIDE)
    ) walk_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .item_ch     (item_if),
        .result_ch   (res_if),
        .cfg_ch      (cfg_if),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always #5 i_clk = ~i_clk;

    // nothing accepted on any channel for too long
    always @(posedge i_clk) begin
        if ((item_if.valid && item_if.ready) || (res_if.valid && res_if.ready)
                || (cfg_if.valid && cfg_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic int unsigned side_used(logic [5:0] v);
        if (v == 0) return 1;
        if (v > MAX_SIDE) return MAX_SIDE;
        return v;
    endfunction

    // mostly small grids, now and then zero, larger, maximum or oversize values
    function automatic logic [5:0] pick_side();
        int r;
        r = $urandom_range(0, 19);
        if (r < 14) return 6'($urandom_range(1, 8));
        if (r < 15) return 6'd0;
        if (r < 17) return 6'($urandom_range(9, 31));
        return 6'($urandom_range(32, 63));
    endfunction

    task automatic send_word(logic kind, logic [15:0] rnd);
        int gap;
        gap = idle_on ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            item_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_if.valid <= 1'b1;
        item_if.kind <= kind;
        item_if.random_word <= rnd;
        do @(posedge i_clk); while (!item_if.ready);
        words_sent++;
    endtask

    task automatic wait_results_done();
        item_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [mbw_pkg::CFG_IDX_W-1:0] idx,
                             logic [mbw_pkg::CFG_DATA_W-1:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data <= val;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic run_walk(logic [5:0] w, logic [5:0] h);
        int unsigned cells;
        int unsigned steps;
        write_reg(mbw_pkg::CFG_GRID_WIDTH, w);
        write_reg(mbw_pkg::CFG_GRID_HEIGHT, h);
        cells = side_used(w) * side_used(h);
        steps = (cells <= 64) ? cells - 1 + $urandom_range(0, 3) : $urandom_range(20, 120);
        send_word(mbw_pkg::KIND_START, 16'($urandom));
        repeat (steps) begin
            // now and then a word of random kind, which may restart the walk
            if ($urandom_range(0, 29) == 0) begin
                send_word(1'($urandom), 16'($urandom));
            end else begin
                send_word(KIND_STEP, 16'($urandom));
            end
        end
        wait_results_done();
    endtask

    initial begin : result_sink
        int gap;
        res_if.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                res_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            gap = idle_on ? $urandom_range(0, 15) : 0;
            if (gap > 0) begin
                res_if.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge i_clk); while (!res_if.valid);
        end
    end

    initial begin : stimulus
        int phase;
        i_rst_n <= 1'b0;
        item_if.valid <= 1'b0;
        item_if.kind <= mbw_pkg::KIND_START;
        item_if.random_word <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.index <= mbw_pkg::CFG_GRID_WIDTH;
        cfg_if.data <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset size 8 by 8: steps ahead of any start, then a short walk
        send_word(KIND_STEP, 16'hFFFF);
        send_word(KIND_STEP, 16'h0000);
        send_word(mbw_pkg::KIND_START, 16'h0000);
        send_word(KIND_STEP, 16'h0000);
        send_word(KIND_STEP, 16'hFFFF);
        send_word(KIND_STEP, 16'h0001);
        send_word(KIND_STEP, 16'h0002);
        send_word(KIND_STEP, 16'h5555);
        send_word(KIND_STEP, 16'hAAAA);
        wait_results_done();

        // zero sizes act as one cell: complete at once and stays complete
        write_reg(mbw_pkg::CFG_GRID_WIDTH, 6'd0);
        write_reg(mbw_pkg::CFG_GRID_HEIGHT, 6'd0);
        send_word(mbw_pkg::KIND_START, 16'hFFFF);
        send_word(KIND_STEP, 16'h1234);
        send_word(KIND_STEP, 16'hFFFF);
        wait_results_done();

        // oversize width clamps; a width written mid-walk waits for the next start
        write_reg(mbw_pkg::CFG_GRID_WIDTH, 6'd63);
        write_reg(mbw_pkg::CFG_GRID_HEIGHT, 6'd2);
        send_word(mbw_pkg::KIND_START, 16'h0000);
        repeat (4) send_word(KIND_STEP, 16'($urandom));
        wait_results_done();
        write_reg(mbw_pkg::CFG_GRID_WIDTH, 6'd3);
        repeat (2) send_word(KIND_STEP, 16'($urandom));
        wait_results_done();

        // 3 by 2 walked to the last carve, then one step past it
        send_word(mbw_pkg::KIND_START, 16'h0000);
        repeat (6) send_word(KIND_STEP, 16'($urandom));
        wait_results_done();

        phase = 0;
        while (words_sent < ITEM_TARGET) begin
            idle_on = $urandom_range(0, 3) != 0;
            if (phase == 1) begin
                // result side holds off while steps keep coming
                hold_req = 1'b1;
                run_walk(6'd8, 6'd6);
            end else begin
                run_walk(pick_side(), pick_side());
            end
            phase++;
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
